// ===== sv/acc_pkg.sv =====
// ----------------------------------------------------------------------------
// acc_pkg
// Shared widths, operation codes and controller states of the aging counter
// cache.
// ----------------------------------------------------------------------------
package acc_pkg;

  localparam int OP_BITS      = 2;
  localparam int KEY_BITS     = 32;
  localparam int VALUE_BITS   = 32;
  localparam int COUNT_BITS   = 5;
  localparam int ENTRIES_DEF  = 16;
  localparam int AGE_BITS_DEF = 31;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [OP_BITS-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_VICTIM,
    ST_DONE
  } state_t;

endpackage

// ===== sv/acc_if.sv =====
// ----------------------------------------------------------------------------
// acc_in_if / acc_out_if
// Valid/ready channels for cache requests and their results.
// ----------------------------------------------------------------------------
interface acc_in_if;
  logic                            valid;
  logic                            ready;
  logic [acc_pkg::OP_BITS-1:0]     op;
  logic [acc_pkg::KEY_BITS-1:0]    item_key;
  logic [acc_pkg::VALUE_BITS-1:0]  item_value;

  modport source (output valid, op, item_key, item_value, input ready);
  modport sink   (input valid, op, item_key, item_value, output ready);
endinterface

interface acc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            hit;
  logic [acc_pkg::VALUE_BITS-1:0]  hit_value;
  logic                            evicted_valid;
  logic [acc_pkg::KEY_BITS-1:0]    evicted_key;
  logic [acc_pkg::VALUE_BITS-1:0]  evicted_value;
  logic [acc_pkg::COUNT_BITS-1:0]  removed_count;

  modport source (output valid, hit, hit_value, evicted_valid, evicted_key, evicted_value,
                  removed_count, input ready);
  modport sink   (input valid, hit, hit_value, evicted_valid, evicted_key, evicted_value,
                  removed_count, output ready);
endinterface

// ===== sv/aging_counter_cache_top.sv =====
// ----------------------------------------------------------------------------
// aging_counter_cache_top
// Fully associative key/value cache with aging-counter replacement.
// ----------------------------------------------------------------------------
// in_ch carries one request: op (lookup, add, remove), key and value. Each
// request gives exactly one result on out_ch: hit and hit value for a
// lookup, the displaced entry for an add, the number of removed slots for a
// remove, all zero for an unused op code.
// Keys, values and ages sit in one single-port-write memory with a registered
// read; valid bits and age-written bits are flip-flops.
// Every lookup, add or remove sweeps all slots, one memory read per cycle, and
// writes each slot read back (a remove writes back only the matching slots it
// clears); an add then writes the victim after the sweep. The result is loaded
// into the output register in ST_DONE, after the sweep (after ST_VICTIM for an
// add). An unused op code skips the sweep and goes straight to ST_DONE; the
// next request is taken once the block is back in ST_IDLE.
// The block works on one request at a time; in_ch.ready is high while idle,
// also while a finished result still waits in the output register.
// Reset empties the cache at once (no clearing pass) and drops any result.
// When out_ch stalls, a finished request waits until the output register is
// free and no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module aging_counter_cache_top #(
  parameter int ENTRIES  = acc_pkg::ENTRIES_DEF,
  parameter int AGE_BITS = acc_pkg::AGE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  acc_in_if.sink      in_ch,
  acc_out_if.source   out_ch
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  typedef struct packed {
    logic [acc_pkg::KEY_BITS-1:0]   key;
    logic [acc_pkg::VALUE_BITS-1:0] value;
    logic [AGE_BITS-1:0]            age;
  } entry_t;

  acc_pkg::state_t state_r, state_nxt;

  logic [acc_pkg::OP_BITS-1:0]    op_r;
  logic [acc_pkg::KEY_BITS-1:0]   key_r;
  logic [acc_pkg::VALUE_BITS-1:0] val_r;

  entry_t               mem [ENTRIES];
  entry_t               rd_data_r;
  logic [ENTRIES-1:0]   valid_r;
  logic [ENTRIES-1:0]   aw_r;

  logic [CW-1:0]        rd_cnt_r;
  logic                 p_vld_r;
  logic [AW-1:0]        p_idx_r;

  logic                            hit_r;
  logic [acc_pkg::VALUE_BITS-1:0]  hval_r;
  logic [AGE_BITS-1:0]             min_age_r;
  logic [AW-1:0]                   vic_idx_r;
  logic                            vic_valid_r;
  logic [acc_pkg::KEY_BITS-1:0]    vic_key_r;
  logic [acc_pkg::VALUE_BITS-1:0]  vic_val_r;
  logic [CW-1:0]                   cnt_r;

  logic                            out_vld_r;
  logic                            out_hit_r;
  logic [acc_pkg::VALUE_BITS-1:0]  out_hval_r;
  logic                            out_ev_r;
  logic [acc_pkg::KEY_BITS-1:0]    out_ekey_r;
  logic [acc_pkg::VALUE_BITS-1:0]  out_eval_r;
  logic [acc_pkg::COUNT_BITS-1:0]  out_cnt_r;

  logic            in_fire;
  logic            op_known;
  logic            issue;
  logic [AW-1:0]   rd_addr;
  logic [AGE_BITS-1:0] age_old;
  logic [AGE_BITS-1:0] age_dec;
  logic            slot_vld;
  logic            p_match;
  logic            sweep_last;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  entry_t          mem_wdata;
  logic            vld_we;
  logic            vld_wdata;
  logic            out_load;

  logic                            res_hit;
  logic [acc_pkg::VALUE_BITS-1:0]  res_hval;
  logic                            res_ev;
  logic [acc_pkg::KEY_BITS-1:0]    res_ekey;
  logic [acc_pkg::VALUE_BITS-1:0]  res_eval;
  logic [acc_pkg::COUNT_BITS-1:0]  res_cnt;

  assign in_ch.ready = (state_r == acc_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign op_known    = (in_ch.op == acc_pkg::OP_LOOKUP) || (in_ch.op == acc_pkg::OP_ADD) ||
                       (in_ch.op == acc_pkg::OP_REMOVE);

  assign issue   = (state_r == acc_pkg::ST_SWEEP) && (rd_cnt_r < CW'(ENTRIES));
  assign rd_addr = rd_cnt_r[AW-1:0];

  // slots whose age was never written read as the reset age
  assign age_old    = aw_r[p_idx_r] ? rd_data_r.age : AGE_MAX;
  assign age_dec    = (age_old == '0) ? '0 : age_old - 1'b1;
  assign slot_vld   = valid_r[p_idx_r];
  assign p_match    = p_vld_r && slot_vld && (rd_data_r.key == key_r);
  assign sweep_last = p_vld_r && (p_idx_r == AW'(ENTRIES - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      acc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_nxt = op_known ? acc_pkg::ST_SWEEP : acc_pkg::ST_DONE;
        end
      end
      acc_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          state_nxt = (op_r == acc_pkg::OP_ADD) ? acc_pkg::ST_VICTIM : acc_pkg::ST_DONE;
        end
      end
      acc_pkg::ST_VICTIM: begin
        state_nxt = acc_pkg::ST_DONE;
      end
      acc_pkg::ST_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          state_nxt = acc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = acc_pkg::ST_IDLE;
    endcase
  end

  // write-back and output load
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = p_idx_r;
    mem_wdata = rd_data_r;
    vld_we    = 1'b0;
    vld_wdata = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      acc_pkg::ST_SWEEP: begin
        if (p_vld_r) begin
          unique case (op_r)
            acc_pkg::OP_LOOKUP: begin
              mem_we        = 1'b1;
              mem_wdata.age = (p_match && !hit_r) ? AGE_MAX : age_dec;
            end
            acc_pkg::OP_ADD: begin
              mem_we        = 1'b1;
              mem_wdata.age = age_dec;
            end
            acc_pkg::OP_REMOVE: begin
              if (p_match) begin
                mem_we        = 1'b1;
                mem_wdata.age = '0;
                vld_we        = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      acc_pkg::ST_VICTIM: begin
        mem_we          = 1'b1;
        mem_waddr       = vic_idx_r;
        mem_wdata.key   = key_r;
        mem_wdata.value = val_r;
        mem_wdata.age   = AGE_MAX;
        vld_we          = 1'b1;
        vld_wdata       = 1'b1;
      end
      acc_pkg::ST_DONE: begin
        out_load = !out_vld_r || out_ch.ready;
      end
      default: ;
    endcase
  end

  // slot store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      aw_r    <= '0;
    end else begin
      if (mem_we) begin
        aw_r[mem_waddr] <= 1'b1;
      end
      if (vld_we) begin
        valid_r[mem_waddr] <= vld_wdata;
      end
    end
  end

  // sweep control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= acc_pkg::ST_IDLE;
      rd_cnt_r <= '0;
      p_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= issue;
      if (in_fire) begin
        rd_cnt_r <= '0;
      end else if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_idx_r <= rd_addr;
    if (in_fire) begin
      op_r   <= in_ch.op;
      key_r  <= in_ch.item_key;
      val_r  <= in_ch.item_value;
      hit_r  <= 1'b0;
      hval_r <= '0;
      cnt_r  <= '0;
    end else if (state_r == acc_pkg::ST_SWEEP && p_vld_r) begin
      // first slot with the smallest age before aging
      if (p_idx_r == '0 || age_old < min_age_r) begin
        min_age_r   <= age_old;
        vic_idx_r   <= p_idx_r;
        vic_valid_r <= slot_vld;
        vic_key_r   <= rd_data_r.key;
        vic_val_r   <= rd_data_r.value;
      end
      if (op_r == acc_pkg::OP_LOOKUP && p_match && !hit_r) begin
        hit_r  <= 1'b1;
        hval_r <= rd_data_r.value;
      end
      if (op_r == acc_pkg::OP_REMOVE && p_match) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // result fields
  always_comb begin
    res_hit  = 1'b0;
    res_hval = '0;
    res_ev   = 1'b0;
    res_ekey = '0;
    res_eval = '0;
    res_cnt  = '0;
    unique case (op_r)
      acc_pkg::OP_LOOKUP: begin
        res_hit  = hit_r;
        res_hval = hval_r;
      end
      acc_pkg::OP_ADD: begin
        res_ev   = vic_valid_r;
        res_ekey = vic_valid_r ? vic_key_r : '0;
        res_eval = vic_valid_r ? vic_val_r : '0;
      end
      acc_pkg::OP_REMOVE: begin
        res_cnt = (32'(cnt_r) > 32'(acc_pkg::COUNT_MAX)) ? acc_pkg::COUNT_MAX
                                                          : acc_pkg::COUNT_BITS'(cnt_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hit_r  <= res_hit;
      out_hval_r <= res_hval;
      out_ev_r   <= res_ev;
      out_ekey_r <= res_ekey;
      out_eval_r <= res_eval;
      out_cnt_r  <= res_cnt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.hit_value     = out_hval_r;
  assign out_ch.evicted_valid = out_ev_r;
  assign out_ch.evicted_key   = out_ekey_r;
  assign out_ch.evicted_value = out_eval_r;
  assign out_ch.removed_count = out_cnt_r;

endmodule

// ===== sv/acc_checker.sv =====
// ----------------------------------------------------------------------------
// acc_checker
// Port-level checks of the aging counter cache, bound to the top level.
// ----------------------------------------------------------------------------
module acc_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic                            out_hit,
  input  logic [acc_pkg::VALUE_BITS-1:0]  out_hit_value,
  input  logic                            out_evicted_valid,
  input  logic [acc_pkg::KEY_BITS-1:0]    out_evicted_key,
  input  logic [acc_pkg::VALUE_BITS-1:0]  out_evicted_value,
  input  logic [acc_pkg::COUNT_BITS-1:0]  out_removed_count
);

  // a result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // one request in flight at a time
  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // a result reports one kind of operation only
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted_valid) &&
                  (out_removed_count == '0 || (!out_hit && !out_evicted_valid)))
    else $error("result mixes operations");

  // unused payload fields read as zero
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hit || out_hit_value == '0) &&
                  (out_evicted_valid || (out_evicted_key == '0 && out_evicted_value == '0)))
    else $error("stale payload in result");

endmodule

bind aging_counter_cache_top acc_checker u_acc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_hit           (out_ch.hit),
  .out_hit_value     (out_ch.hit_value),
  .out_evicted_valid (out_ch.evicted_valid),
  .out_evicted_key   (out_ch.evicted_key),
  .out_evicted_value (out_ch.evicted_value),
  .out_removed_count (out_ch.removed_count)
);
